@@ rtl/core/lirs_pkg.sv @@
// Package for the linear interpolation buffer resampler.
// Holds widths, register indexes, reset values and the controller state type.
// Depends on nothing.
package lirs_pkg;

    localparam int MAX_IN_DEF  = 4096;
    localparam int MAX_OUT_DEF = 2048;

    localparam int SAMPLE_W = 16;
    localparam int RATE_W   = 16;
    localparam int PEAK_W   = 16;
    localparam int NZ_W     = 13;
    localparam int FRAC_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_RATE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_INPUT  = 2'd2;

    localparam logic [RATE_W-1:0] SOURCE_RATE_RST = 16'd22020;
    localparam logic [RATE_W-1:0] DEST_RATE_RST   = 16'd48000;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLOSE,
        S_CLOSE_WAIT,
        S_POS,
        S_POS_WAIT,
        S_RD_A,
        S_RD_B,
        S_MULT,
        S_SUM,
        S_OUT
    } state_t;

endpackage

@@ rtl/core/lirs_if.sv @@
// Item channels of the resampler: input items and result items.
// Depends on lirs_pkg for field widths.
interface lirs_in_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic signed [lirs_pkg::SAMPLE_W-1:0] left_in;
    logic signed [lirs_pkg::SAMPLE_W-1:0] right_in;
    logic                              last_in;

    modport source (output valid, cmd, left_in, right_in, last_in, input ready);
    modport sink   (input valid, cmd, left_in, right_in, last_in, output ready);
endinterface

interface lirs_out_if;
    logic                              valid;
    logic                              ready;
    logic                              frame_valid;
    logic signed [lirs_pkg::SAMPLE_W-1:0] left_out;
    logic signed [lirs_pkg::SAMPLE_W-1:0] right_out;
    logic                              last_out;
    logic [lirs_pkg::PEAK_W-1:0]       peak;
    logic [lirs_pkg::NZ_W-1:0]         nonzero_count;

    modport source (output valid, frame_valid, left_out, right_out, last_out, peak,
                    nonzero_count, input ready);
    modport sink   (input valid, frame_valid, left_out, right_out, last_out, peak,
                    nonzero_count, output ready);
endinterface

@@ rtl/core/lirs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lirs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/lirs_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// No dependencies.
module lirs_div #(
    parameter int DW = 41,
    parameter int VW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DW-1]};
        diff      = trial - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!diff[VW])
            begin
                rem_next = diff[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/core/linear_interp_buffer_resampler.sv @@
// Top level of the linear interpolation buffer resampler.
// Depends on lirs_pkg, lirs_if, lirs_ram and lirs_div.
//
// A load item marked last closes the buffer and, unless drop input is set, keeps the
// block busy while the output frame count is divided out (dividend width DW =
// clog2(MAX_OUT+1) + clog2(MAX_IN+1) + 16, 41 at the defaults); other loads do not hold
// it. A fetch with nothing pending goes straight to the output; otherwise, unless the
// position is trivially zero, it is divided out first by the serial divider, one quotient
// bit per cycle. The next item is accepted while a result waits in the output register.
module linear_interp_buffer_resampler #(
    parameter int MAX_IN  = lirs_pkg::MAX_IN_DEF,
    parameter int MAX_OUT = lirs_pkg::MAX_OUT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lirs_in_if.sink                           in_items,
    lirs_out_if.source                        out_items,
    input  logic                              cfg_we,
    input  logic [lirs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lirs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int IW = $clog2(MAX_IN + 1);
    localparam int AW = $clog2(MAX_IN);
    localparam int OW = $clog2(MAX_OUT + 1);
    localparam int FW = lirs_pkg::FRAC_W;
    localparam int SW = lirs_pkg::SAMPLE_W;
    localparam int RW = lirs_pkg::RATE_W;
    localparam int NW = lirs_pkg::NZ_W;
    localparam int PW = lirs_pkg::PEAK_W;
    localparam int DW = OW + IW + FW;
    localparam int VW = (OW > RW) ? OW : RW;

    lirs_pkg::state_t state_reg, state_next;

    logic [RW-1:0] src_rate_reg;
    logic [RW-1:0] dst_rate_reg;
    logic          drop_reg;

    logic [IW-1:0] loaded_reg;
    logic [RW-1:0] rem_reg;
    logic [OW-1:0] to_emit_reg;
    logic [OW-1:0] emit_reg;
    logic [PW-1:0] peak_reg;
    logic [NW-1:0] nz_reg;
    logic          closed_reg;

    logic [IW+FW-1:0] pos_reg;
    logic signed [SW-1:0]  a_l_reg, a_r_reg;
    logic signed [2*SW+1:0] prod_l_reg, prod_r_reg;

    logic                 res_fv_reg, res_last_reg;
    logic signed [SW-1:0] res_l_reg, res_r_reg;
    logic [PW-1:0]        res_peak_reg;
    logic [NW-1:0]        res_nz_reg;

    logic                 out_valid_reg;
    logic                 out_fv_reg, out_last_reg;
    logic signed [SW-1:0] out_l_reg, out_r_reg;
    logic [PW-1:0]        out_peak_reg;
    logic [NW-1:0]        out_nz_reg;

    logic          accept;
    logic          is_load;
    logic          pending;
    logic          trivial_pos;
    logic          slot_free;
    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [VW-1:0] div_divisor;
    logic          div_done;
    logic [DW-1:0] div_quo;
    logic [VW-1:0] div_rem;
    logic [RW-1:0] src_rate_eff;
    logic [IW+RW-1:0] scaled;
    logic [OW+IW-1:0] fpos;
    logic [IW-1:0] src_idx, src_raw, nxt_idx;
    logic [IW:0]   src_inc;
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [2*SW-1:0] ram_rdata;
    logic signed [SW:0]  diff_l, diff_r;
    logic signed [FW:0]  frac_s;
    logic signed [2*SW+1:0] q_l, q_r;
    logic signed [SW-1:0] v_l, v_r;
    logic signed [SW:0]   v_l_w, v_r_w;
    logic [SW:0]     mag_l, mag_r;
    logic [PW-1:0]   peak_new;
    logic [NW-1:0]   nz_new;
    logic [OW-1:0]   emit_new;
    logic [DW-1:0]   clamped;

    assign accept      = in_items.valid && in_items.ready;
    assign is_load     = in_items.cmd == lirs_pkg::CMD_LOAD;
    assign pending     = closed_reg && (emit_reg < to_emit_reg);
    assign trivial_pos = (to_emit_reg <= OW'(1)) || (loaded_reg <= IW'(1));
    assign slot_free   = !out_valid_reg || out_items.ready;

    assign src_rate_eff = (src_rate_reg == '0) ? RW'(1) : src_rate_reg;
    assign scaled       = (IW+RW)'(loaded_reg * dst_rate_reg) + (IW+RW)'(rem_reg);
    assign fpos         = (OW+IW)'(emit_reg * (loaded_reg - 1'b1));
    assign clamped      = (div_quo > DW'(MAX_OUT)) ? DW'(MAX_OUT) : div_quo;

    assign src_raw = pos_reg[IW+FW-1:FW];
    assign src_idx = (src_raw >= loaded_reg) ? loaded_reg - 1'b1 : src_raw;
    assign src_inc = {1'b0, src_idx} + 1'b1;
    assign nxt_idx = (src_inc < {1'b0, loaded_reg}) ? src_inc[IW-1:0] : src_idx;

    assign frac_s = $signed({1'b0, pos_reg[FW-1:0]});
    assign diff_l = (SW+1)'($signed(ram_rdata[SW-1:0])) - (SW+1)'(a_l_reg);
    assign diff_r = (SW+1)'($signed(ram_rdata[2*SW-1:SW])) - (SW+1)'(a_r_reg);
    assign q_l    = prod_l_reg >>> FW;
    assign q_r    = prod_r_reg >>> FW;
    assign v_l_w  = (SW+1)'(a_l_reg) + q_l[SW:0];
    assign v_r_w  = (SW+1)'(a_r_reg) + q_r[SW:0];
    assign v_l    = v_l_w[SW-1:0];
    assign v_r    = v_r_w[SW-1:0];
    assign mag_l  = v_l[SW-1] ? (SW+1)'(0) - (SW+1)'(v_l) : (SW+1)'(v_l);
    assign mag_r  = v_r[SW-1] ? (SW+1)'(0) - (SW+1)'(v_r) : (SW+1)'(v_r);

    always_comb
    begin
        peak_new = peak_reg;
        if (mag_l[PW-1:0] > peak_new)
        begin
            peak_new = mag_l[PW-1:0];
        end
        if (mag_r[PW-1:0] > peak_new)
        begin
            peak_new = mag_r[PW-1:0];
        end
        nz_new   = nz_reg + NW'(v_l != '0) + NW'(v_r != '0);
        emit_new = emit_reg + 1'b1;
    end

    lirs_ram #(
        .WIDTH(2 * SW),
        .DEPTH(MAX_IN)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (closed_reg ? AW'(0) : loaded_reg[AW-1:0]),
        .wdata ({in_items.right_in, in_items.left_in}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lirs_div #(
        .DW(DW),
        .VW(VW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lirs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (is_load)
                    begin
                        if (in_items.last_in && !drop_reg)
                        begin
                            state_next = lirs_pkg::S_CLOSE;
                        end
                    end
                    else if (!pending)
                    begin
                        state_next = lirs_pkg::S_OUT;
                    end
                    else if (trivial_pos)
                    begin
                        state_next = lirs_pkg::S_RD_A;
                    end
                    else
                    begin
                        state_next = lirs_pkg::S_POS;
                    end
                end
            end
            lirs_pkg::S_CLOSE:      state_next = lirs_pkg::S_CLOSE_WAIT;
            lirs_pkg::S_CLOSE_WAIT:
            begin
                if (div_done)
                begin
                    state_next = lirs_pkg::S_IDLE;
                end
            end
            lirs_pkg::S_POS:        state_next = lirs_pkg::S_POS_WAIT;
            lirs_pkg::S_POS_WAIT:
            begin
                if (div_done)
                begin
                    state_next = lirs_pkg::S_RD_A;
                end
            end
            lirs_pkg::S_RD_A:       state_next = lirs_pkg::S_RD_B;
            lirs_pkg::S_RD_B:       state_next = lirs_pkg::S_MULT;
            lirs_pkg::S_MULT:       state_next = lirs_pkg::S_SUM;
            lirs_pkg::S_SUM:        state_next = lirs_pkg::S_OUT;
            lirs_pkg::S_OUT:
            begin
                if (slot_free)
                begin
                    state_next = lirs_pkg::S_IDLE;
                end
            end
            default:                state_next = lirs_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_items.ready = 1'b0;
        div_start      = 1'b0;
        div_dividend   = DW'(scaled);
        div_divisor    = VW'(src_rate_eff);
        ram_raddr      = src_idx[AW-1:0];
        case (state_reg)
            lirs_pkg::S_IDLE:
            begin
                in_items.ready = 1'b1;
            end
            lirs_pkg::S_CLOSE:
            begin
                div_start = 1'b1;
            end
            lirs_pkg::S_POS:
            begin
                div_start    = 1'b1;
                div_dividend = {fpos, {FW{1'b0}}};
                div_divisor  = VW'(to_emit_reg - 1'b1);
            end
            lirs_pkg::S_RD_B:
            begin
                ram_raddr = nxt_idx[AW-1:0];
            end
            default:
            begin
                in_items.ready = 1'b0;
            end
        endcase
        ram_we = accept && is_load && (closed_reg || (loaded_reg < IW'(MAX_IN)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lirs_pkg::S_IDLE;
            src_rate_reg  <= lirs_pkg::SOURCE_RATE_RST;
            dst_rate_reg  <= lirs_pkg::DEST_RATE_RST;
            drop_reg      <= 1'b0;
            loaded_reg    <= '0;
            rem_reg       <= '0;
            to_emit_reg   <= '0;
            emit_reg      <= '0;
            peak_reg      <= '0;
            nz_reg        <= '0;
            closed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    lirs_pkg::CFG_SOURCE_RATE: src_rate_reg <= cfg_wdata[RW-1:0];
                    lirs_pkg::CFG_DEST_RATE:   dst_rate_reg <= cfg_wdata[RW-1:0];
                    lirs_pkg::CFG_DROP_INPUT:  drop_reg     <= cfg_wdata[0];
                    default:                   drop_reg     <= drop_reg;
                endcase
            end
            if (accept && is_load)
            begin
                if (closed_reg)
                begin
                    loaded_reg  <= IW'(1);
                    to_emit_reg <= '0;
                    emit_reg    <= '0;
                    peak_reg    <= '0;
                    nz_reg      <= '0;
                    closed_reg  <= in_items.last_in;
                end
                else
                begin
                    if (loaded_reg < IW'(MAX_IN))
                    begin
                        loaded_reg <= loaded_reg + 1'b1;
                    end
                    if (in_items.last_in)
                    begin
                        closed_reg  <= 1'b1;
                        to_emit_reg <= '0;
                        emit_reg    <= '0;
                        peak_reg    <= '0;
                        nz_reg      <= '0;
                    end
                end
            end
            if (state_reg == lirs_pkg::S_CLOSE_WAIT && div_done)
            begin
                rem_reg     <= div_rem[RW-1:0];
                to_emit_reg <= clamped[OW-1:0];
            end
            if (state_reg == lirs_pkg::S_SUM)
            begin
                peak_reg <= peak_new;
                nz_reg   <= nz_new;
                emit_reg <= emit_new;
            end
            if (state_reg == lirs_pkg::S_OUT && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_items.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lirs_pkg::S_IDLE)
        begin
            pos_reg      <= '0;
            res_fv_reg   <= 1'b0;
            res_last_reg <= 1'b0;
            res_l_reg    <= '0;
            res_r_reg    <= '0;
            res_peak_reg <= '0;
            res_nz_reg   <= '0;
        end
        if (state_reg == lirs_pkg::S_POS_WAIT && div_done)
        begin
            pos_reg <= div_quo[IW+FW-1:0];
        end
        if (state_reg == lirs_pkg::S_RD_B)
        begin
            a_l_reg <= ram_rdata[SW-1:0];
            a_r_reg <= ram_rdata[2*SW-1:SW];
        end
        if (state_reg == lirs_pkg::S_SUM)
        begin
            res_fv_reg   <= 1'b1;
            res_l_reg    <= v_l;
            res_r_reg    <= v_r;
            res_last_reg <= emit_new == to_emit_reg;
            res_peak_reg <= (emit_new == to_emit_reg) ? peak_new : '0;
            res_nz_reg   <= (emit_new == to_emit_reg) ? nz_new : '0;
        end
        if (state_reg == lirs_pkg::S_OUT && slot_free)
        begin
            out_fv_reg   <= res_fv_reg;
            out_l_reg    <= res_l_reg;
            out_r_reg    <= res_r_reg;
            out_last_reg <= res_last_reg;
            out_peak_reg <= res_peak_reg;
            out_nz_reg   <= res_nz_reg;
        end
        prod_l_reg <= (2*SW+2)'(diff_l * frac_s);
        prod_r_reg <= (2*SW+2)'(diff_r * frac_s);
    end

    assign out_items.valid         = out_valid_reg;
    assign out_items.frame_valid   = out_fv_reg;
    assign out_items.left_out      = out_l_reg;
    assign out_items.right_out     = out_r_reg;
    assign out_items.last_out      = out_last_reg;
    assign out_items.peak          = out_peak_reg;
    assign out_items.nonzero_count = out_nz_reg;

endmodule
